// ----- rtl/array_deque_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Array deque assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ARRAY_DEQUE_UNIT_DEFINES_SVH
`define ARRAY_DEQUE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ADQ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be true outside reset
`define ADQ_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ADQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define ADQ_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ----- rtl/adq_pkg.sv -----
// ----------------------------------------------------------------------------
// Array deque package
// Operation and status codes, per-cell lane commands.
// ----------------------------------------------------------------------------
`default_nettype none

package adq_pkg;

	localparam int WORD_W = 32;

	typedef enum logic [1:0] {
		OP_INS_L = 2'd0,
		OP_INS_R = 2'd1,
		OP_DEL_L = 2'd2,
		OP_DEL_R = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// one lane of the cell chain
	typedef struct packed {
		logic shr;   // take the left neighbor (cell 0 takes the new word)
		logic shl;   // take the right neighbor
		logic wr;    // write the new word where the write index matches
	} lane_cmd_t;

	// fr lane: front element in cell 0; rr lane: rear element in cell 0
	typedef struct packed {
		lane_cmd_t fr;
		lane_cmd_t rr;
	} cell_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/array_deque_unit.sv -----
// ----------------------------------------------------------------------------
// Array deque unit
// Double-ended queue of signed 32-bit words in DEPTH slots.
// ----------------------------------------------------------------------------
// One operation is taken per clock: busy never rises, so start may be held
// high every cycle. Each operation gives one result on removed_word, status,
// is_empty and is_full, marked by done in the cycle after start; the receiver
// cannot stall, so it must take the result in that cycle. The words live in a
// chain of DEPTH cells with two lanes, one ordered from the front element and
// one from the rear element, so both ends are read from cell 0 and every
// shift of the chain is done at once. The deque reports full, and
// rejects inserts, whenever the rear index sits at the last slot.
// ----------------------------------------------------------------------------
`default_nettype none

module array_deque_unit
	import adq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic [1:0]               op,
	input  wire logic signed [WORD_W-1:0] value,
	output logic                          done,
	output logic signed [WORD_W-1:0]      removed_word,
	output logic [1:0]                    status,
	output logic                          is_empty,
	output logic                          is_full
);

	localparam int IDXW = $clog2(DEPTH);

	cell_cmd_t                cmd;
	logic [IDXW-1:0]          wr_idx;
	logic signed [WORD_W-1:0] fr_w [DEPTH];
	logic signed [WORD_W-1:0] rr_w [DEPTH];

	assign busy = 1'b0;

	adq_ctrl #(
		.DEPTH (DEPTH),
		.IDXW  (IDXW)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.op           (op),
		.fr0          (fr_w[0]),
		.rr0          (rr_w[0]),
		.cmd          (cmd),
		.wr_idx       (wr_idx),
		.done         (done),
		.removed_word (removed_word),
		.status       (status),
		.is_empty     (is_empty),
		.is_full      (is_full)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [WORD_W-1:0] l_fr, l_rr, r_fr, r_rr;

		if (i == 0) begin : g_head
			assign l_fr = value;
			assign l_rr = value;
		end else begin : g_mid
			assign l_fr = fr_w[i-1];
			assign l_rr = rr_w[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign r_fr = fr_w[i];
			assign r_rr = rr_w[i];
		end else begin : g_body
			assign r_fr = fr_w[i+1];
			assign r_rr = rr_w[i+1];
		end

		adq_cell #(
			.IDXW  (IDXW),
			.INDEX (i)
		) u_cell (
			.clk      (clk),
			.cmd      (cmd),
			.wr_idx   (wr_idx),
			.value    (value),
			.left_fr  (l_fr),
			.left_rr  (l_rr),
			.right_fr (r_fr),
			.right_rr (r_rr),
			.fr       (fr_w[i]),
			.rr       (rr_w[i])
		);
	end

endmodule

`default_nettype wire

// ----- rtl/adq_cell.sv -----
// ----------------------------------------------------------------------------
// Array deque cell
// Holds one slot of the front-ordered lane and one of the rear-ordered lane.
// ----------------------------------------------------------------------------
`default_nettype none

module adq_cell
	import adq_pkg::*;
#(
	parameter int IDXW  = 4,
	parameter int INDEX = 0
) (
	input  wire logic                     clk,
	input  wire cell_cmd_t                cmd,
	input  wire logic [IDXW-1:0]          wr_idx,
	input  wire logic signed [WORD_W-1:0] value,
	input  wire logic signed [WORD_W-1:0] left_fr,
	input  wire logic signed [WORD_W-1:0] left_rr,
	input  wire logic signed [WORD_W-1:0] right_fr,
	input  wire logic signed [WORD_W-1:0] right_rr,
	output logic signed [WORD_W-1:0]      fr,
	output logic signed [WORD_W-1:0]      rr
);

	logic signed [WORD_W-1:0] fr_q;
	logic signed [WORD_W-1:0] rr_q;
	logic                     hit;

	assign hit = (wr_idx == IDXW'(INDEX));

	always_ff @(posedge clk) begin
		if (cmd.fr.shr) begin
			fr_q <= left_fr;
		end else if (cmd.fr.shl) begin
			fr_q <= right_fr;
		end else if (cmd.fr.wr && hit) begin
			fr_q <= value;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rr.shr) begin
			rr_q <= left_rr;
		end else if (cmd.rr.shl) begin
			rr_q <= right_rr;
		end else if (cmd.rr.wr && hit) begin
			rr_q <= value;
		end
	end

	assign fr = fr_q;
	assign rr = rr_q;

endmodule

`default_nettype wire

// ----- rtl/adq_ctrl.sv -----
// ----------------------------------------------------------------------------
// Array deque control
// Front/rear indices, empty flag, cell commands and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "array_deque_unit_defines.svh"

module adq_ctrl
	import adq_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int IDXW  = 4
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [1:0]               op,
	input  wire logic signed [WORD_W-1:0] fr0,
	input  wire logic signed [WORD_W-1:0] rr0,
	output cell_cmd_t                     cmd,
	output logic [IDXW-1:0]               wr_idx,
	output logic                          done,
	output logic signed [WORD_W-1:0]      removed_word,
	output logic [1:0]                    status,
	output logic                          is_empty,
	output logic                          is_full
);

	localparam int CW = IDXW + 1;

	op_t                      opc;
	logic [IDXW-1:0]          front_q, rear_q, front_n, rear_n;
	logic                     empty_q, empty_n;
	logic                     full;
	logic [CW-1:0]            cnt;
	status_t                  st;
	logic signed [WORD_W-1:0] rem;

	logic                     done_q;
	logic signed [WORD_W-1:0] rem_q;
	status_t                  st_q;
	logic                     empty_res_q, full_res_q;

	assign opc  = op_t'(op);
	assign full = !empty_q && (rear_q == IDXW'(DEPTH - 1));
	assign cnt  = empty_q ? '0 : (CW'(rear_q) - CW'(front_q) + CW'(1));
	// cnt stays below DEPTH whenever an insert is taken
	assign wr_idx = cnt[IDXW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			rear_q  <= '0;
			empty_q <= 1'b1;
		end else begin
			front_q <= front_n;
			rear_q  <= rear_n;
			empty_q <= empty_n;
		end
	end

	always_comb begin
		front_n = front_q;
		rear_n  = rear_q;
		empty_n = empty_q;
		cmd     = '0;
		st      = ST_DONE;
		rem     = '0;
		if (start) begin
			unique case (opc) inside
				OP_INS_L, OP_INS_R: begin
					if (full) begin
						st = ST_FULL;
					end else if (empty_q) begin
						cmd.fr.wr = 1'b1;
						cmd.rr.wr = 1'b1;
						empty_n   = 1'b0;
					end else if (opc == OP_INS_R) begin
						cmd.rr.shr = 1'b1;
						cmd.fr.wr  = 1'b1;
						rear_n     = rear_q + IDXW'(1);
					end else begin
						cmd.fr.shr = 1'b1;
						cmd.rr.wr  = 1'b1;
						// at slot 0 the array shifts right and rear grows
						if (front_q == '0) begin
							rear_n = rear_q + IDXW'(1);
						end else begin
							front_n = front_q - IDXW'(1);
						end
					end
				end
				OP_DEL_L, OP_DEL_R: begin
					if (empty_q) begin
						st = ST_EMPTY;
					end else begin
						if (opc == OP_DEL_L) begin
							rem        = fr0;
							cmd.fr.shl = 1'b1;
						end else begin
							rem        = rr0;
							cmd.rr.shl = 1'b1;
						end
						if (front_q == rear_q) begin
							empty_n = 1'b1;
							front_n = '0;
							rear_n  = '0;
						end else if (opc == OP_DEL_L) begin
							front_n = front_q + IDXW'(1);
						end else begin
							rear_n = rear_q - IDXW'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q       <= rem;
			st_q        <= st;
			empty_res_q <= empty_n;
			full_res_q  <= !empty_n && (rear_n == IDXW'(DEPTH - 1));
		end
	end

	assign done         = done_q;
	assign removed_word = rem_q;
	assign status       = st_q;
	assign is_empty     = empty_res_q;
	assign is_full      = full_res_q;

	`ADQ_NEVER(a_empty_idx, clk, arst_n, empty_q && (front_q != '0 || rear_q != '0), "empty deque with nonzero index")
	`ADQ_NEVER(a_order, clk, arst_n, !empty_q && (front_q > rear_q), "front index past rear index")
	`ADQ_ASSERT(a_full_flag, clk, arst_n, done_q && (st_q == ST_FULL) |-> full_res_q && !empty_res_q, "full reject without full flag")
	`ADQ_ASSERT(a_reject_hold, clk, arst_n, start && full && (opc == OP_INS_L || opc == OP_INS_R) |=> $stable(front_q) && $stable(rear_q) && $stable(empty_q), "rejected insert moved indices")

endmodule

`default_nettype wire

// ----- dv/tb_array_deque_unit.sv -----
// ----------------------------------------------------------------------------
// Array deque unit testbench
// Sends insert and delete commands from a queue, one transfer at a time, and
// predicts each reply with a local copy of the deque. Replies are checked
// field by field when done strobes. The run opens with directed cases (empty,
// shift on left insert, full with free slots on the left, extreme words) and
// continues with fill, drain and mixed random sequences.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_array_deque_unit;
	import adq_pkg::*;

	localparam int DEPTH       = 16;
	localparam int N_ITEMS     = 1450;
	localparam int STALL_LIMIT = 2000;
	localparam int QUIET_TAIL  = 200;

	typedef struct {
		op_t                     kind;
		logic signed [WORD_W-1:0] word;
	} deque_cmd_t;

	typedef struct {
		logic signed [WORD_W-1:0] word;
		status_t                  st;
		logic                     emp;
		logic                     full;
	} deque_reply_t;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	op_t                      op;
	logic signed [WORD_W-1:0] value;
	logic                     done;
	logic signed [WORD_W-1:0] removed_word;
	logic [1:0]               status;
	logic                     is_empty;
	logic                     is_full;

	deque_cmd_t   cmd_queue[$];
	deque_reply_t replies_due[$];

	// local copy of the deque
	logic signed [WORD_W-1:0] slots[DEPTH] = '{default: '0};
	int                       front_pos    = 0;
	int                       rear_pos     = 0;
	bit                       held_none    = 1'b1;

	int n_cmds      = 0;
	int n_sent      = 0;
	int n_checked   = 0;
	int n_errors    = 0;
	int n_full_rej  = 0;
	int n_empty_rej = 0;
	int n_shifts    = 0;
	int peak_fill   = 0;
	int gap_left;
	int stall_cycles;

	array_deque_unit #(
		.DEPTH(DEPTH)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.value       (value),
		.done        (done),
		.removed_word(removed_word),
		.status      (status),
		.is_empty    (is_empty),
		.is_full     (is_full)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic deque_reply_t apply_deque_op(op_t kind, logic signed [WORD_W-1:0] word);
		deque_reply_t r;
		r.word = '0;
		r.st   = ST_DONE;
		if (kind == OP_INS_L || kind == OP_INS_R) begin
			if (!held_none && rear_pos == DEPTH - 1) begin
				r.st = ST_FULL;
				n_full_rej++;
			end else if (held_none) begin
				front_pos = 0;
				rear_pos  = 0;
				slots[0]  = word;
				held_none = 1'b0;
			end else if (kind == OP_INS_R) begin
				rear_pos++;
				slots[rear_pos] = word;
			end else if (front_pos == 0) begin
				for (int i = rear_pos + 1; i > 0; i--)
					slots[i] = slots[i-1];
				rear_pos++;
				slots[0] = word;
				n_shifts++;
			end else begin
				front_pos--;
				slots[front_pos] = word;
			end
		end else begin
			if (held_none) begin
				r.st = ST_EMPTY;
				n_empty_rej++;
			end else begin
				r.word = (kind == OP_DEL_L) ? slots[front_pos] : slots[rear_pos];
				if (front_pos == rear_pos) begin
					held_none = 1'b1;
					front_pos = 0;
					rear_pos  = 0;
				end else if (kind == OP_DEL_L) begin
					front_pos++;
				end else begin
					rear_pos--;
				end
			end
		end
		if (!held_none && rear_pos - front_pos + 1 > peak_fill)
			peak_fill = rear_pos - front_pos + 1;
		r.emp  = held_none;
		r.full = !held_none && rear_pos == DEPTH - 1;
		return r;
	endfunction

	task automatic add_cmd(op_t kind, logic signed [WORD_W-1:0] word);
		deque_cmd_t c;
		c.kind = kind;
		c.word = word;
		cmd_queue.push_back(c);
		n_cmds++;
	endtask

	function automatic logic signed [WORD_W-1:0] pick_word();
		logic signed [WORD_W-1:0] w;
		w = $urandom;
		if ($urandom_range(0, 7) == 0) begin
			case ($urandom_range(0, 3))
				0: w = 32'sh8000_0000;
				1: w = 32'sh7FFF_FFFF;
				2: w = '0;
				default: w = -32'sd1;
			endcase
		end
		return w;
	endfunction

	// driver: holds a command until the transfer, then loads the next or idles
	always @(posedge clk or negedge arst_n) begin
		deque_cmd_t c;
		if (!arst_n) begin
			start    <= 1'b0;
			op       <= OP_INS_L;
			value    <= '0;
			gap_left <= 0;
		end else begin
			if (start && !busy) begin
				replies_due.push_back(apply_deque_op(op, value));
				n_sent++;
			end
			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					start    <= 1'b0;
				end else if (cmd_queue.size() > QUIET_TAIL && $urandom_range(0, 9) == 0) begin
					gap_left <= $urandom_range(0, 18);
					start    <= 1'b0;
				end else if (cmd_queue.size() > 0) begin
					c = cmd_queue.pop_front();
					start <= 1'b1;
					op    <= c.kind;
					value <= c.word;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: one reply per done strobe, checked against the oldest prediction
	always @(posedge clk) begin
		deque_reply_t e;
		if (arst_n && done) begin
			if (replies_due.size() == 0) begin
				$display("%0t: reply with nothing outstanding: word %h status %0d",
					$time, removed_word, status);
				n_errors++;
			end else begin
				e = replies_due.pop_front();
				n_checked++;
				if (removed_word !== e.word) begin
					$display("%0t: removed_word expected %h actual %h",
						$time, e.word, removed_word);
					n_errors++;
				end
				if (status !== e.st) begin
					$display("%0t: status expected %0d actual %0d", $time, e.st, status);
					n_errors++;
				end
				if (is_empty !== e.emp) begin
					$display("%0t: is_empty expected %b actual %b", $time, e.emp, is_empty);
					n_errors++;
				end
				if (is_full !== e.full) begin
					$display("%0t: is_full expected %b actual %b", $time, e.full, is_full);
					n_errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles == STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
			$display("[array_deque_unit] ERROR");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		int mode;
		int seg_len;
		int ins_pct;
		arst_n = 1'b0;

		// deletes on empty, insert into empty, left insert with shift,
		// left insert below a nonzero front, removal of the last word
		add_cmd(OP_DEL_L, 32'sh1234_5678);
		add_cmd(OP_DEL_R, -32'sd1);
		add_cmd(OP_INS_L, 32'sh7FFF_FFFF);
		add_cmd(OP_INS_L, 32'sh8000_0000);
		add_cmd(OP_DEL_L, '0);
		add_cmd(OP_INS_L, '0);
		add_cmd(OP_DEL_R, '0);
		add_cmd(OP_DEL_R, '0);
		// fill to the last slot, then reject on both sides, also with
		// free slots on the left
		for (int i = 0; i < DEPTH; i++)
			add_cmd(OP_INS_R, (i % 2) ? ~(32'sd1 << (2 * i)) : (32'sd1 << (2 * i)));
		add_cmd(OP_INS_L, -32'sd1);
		add_cmd(OP_INS_R, -32'sd1);
		add_cmd(OP_DEL_L, '0);
		add_cmd(OP_INS_L, 32'sh5555_AAAA);

		// random segments: fill, drain and mixed
		while (n_cmds < N_ITEMS) begin
			mode    = $urandom_range(0, 9);
			seg_len = $urandom_range(8, 40);
			if (mode < 4)
				ins_pct = 80;
			else if (mode < 7)
				ins_pct = 20;
			else
				ins_pct = 50;
			for (int k = 0; k < seg_len && n_cmds < N_ITEMS; k++) begin
				if ($urandom_range(0, 99) < ins_pct)
					add_cmd($urandom_range(0, 1) ? OP_INS_R : OP_INS_L, pick_word());
				else
					add_cmd($urandom_range(0, 1) ? OP_DEL_R : OP_DEL_L, pick_word());
			end
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (n_sent != n_cmds)
			@(posedge clk);
		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("checked %0d replies, %0d full and %0d empty rejects, %0d shifting left inserts",
			n_checked, n_full_rej, n_empty_rej, n_shifts);
		$display("peak occupancy %0d of %0d slots, %0d mismatches", peak_fill, DEPTH, n_errors);
		if (n_errors == 0) begin
			$display("[array_deque_unit] OK");
		end else begin
			$display("[array_deque_unit] ERROR");
		end
		$finish;
	end

endmodule
